### rtl/bac_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bac_pkg;

    localparam int LOG_TABLE_BITS = 8;
    localparam int ADC_BITS       = 16;

    // log2 unit: six normalize cells, table read, interpolation multiply, sum
    localparam int NORM_STAGES = 6;
    localparam int LOG_LAT     = NORM_STAGES + 3;

    localparam logic [23:0] LN2_Q24 = 24'd11629080;

    localparam logic signed [39:0] ALT_MAX = 40'sh7F_FFFF_FFFF;
    localparam logic signed [39:0] ALT_MIN = 40'sh80_0000_0000;

    // register map, word index
    localparam logic [2:0] REG_FULL_SCALE = 3'd0;
    localparam logic [2:0] REG_SUPPLY     = 3'd1;
    localparam logic [2:0] REG_ERROR      = 3'd2;
    localparam logic [2:0] REG_OFFSET     = 3'd3;
    localparam logic [2:0] REG_GAIN       = 3'd4;
    localparam logic [2:0] REG_BASE       = 3'd5;
    localparam logic [2:0] REG_ALT_SCALE  = 3'd6;

    localparam logic [16:0] RST_FULL_SCALE = 17'd4096;
    localparam logic [15:0] RST_SUPPLY     = 16'd5000;
    localparam logic [15:0] RST_ERROR      = 16'd0;
    localparam logic [31:0] RST_OFFSET     = 32'd1593835;
    localparam logic [31:0] RST_GAIN       = 32'd150995;
    localparam logic [31:0] RST_BASE       = 32'd6640435;
    localparam logic [31:0] RST_ALT_SCALE  = 32'd1918259;

    // log2 of m / 2^30 for m in [2^30, 2^31), q0.30, by repeated squaring
    function automatic logic [31:0] log2_mant(input logic [63:0] m_in);
        logic [63:0] m;
        logic [31:0] r;
        int k;
        m = m_in;
        r = '0;
        for (k = 0; k < 30; k++)
        begin
            m = (m * m) >> 30;
            r = {r[30:0], 1'b0};
            if (m >= 64'h0000_0000_8000_0000)
            begin
                m = m >> 1;
                r[0] = 1'b1;
            end
        end
        return r;
    endfunction

    // one entry of the interpolation table, evaluated at elaboration
    function automatic logic [31:0] log_entry(input int i, input int tb);
        logic [63:0] m;
        m = 64'((1 << tb) + i) << (30 - tb);
        if (i == (1 << tb))
            return 32'h4000_0000;
        return log2_mant(m);
    endfunction

endpackage

`default_nettype wire

### rtl/bac_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bac_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] adc_code;
    logic [23:0] temperature_q8;

    modport source (output valid, adc_code, temperature_q8, input ready);
    modport sink (input valid, adc_code, temperature_q8, output ready);
endinterface

interface bac_out_if;
    logic               valid;
    logic               ready;
    logic signed [39:0] altitude_q16;
    logic               invalid;

    modport source (output valid, altitude_q16, invalid, input ready);
    modport sink (input valid, altitude_q16, invalid, output ready);
endinterface

`default_nettype wire

### rtl/bac_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// one restoring division step: one quotient bit per cell
module bac_div_cell #(
    parameter int NW = 56,
    parameter int DW = 17,
    parameter int SW = 24
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire logic [NW-1:0] in_num,
    input  wire logic [DW-1:0] in_rem,
    input  wire logic [SW-1:0] in_side,
    input  wire logic [DW-1:0] d,
    output logic               out_valid,
    output logic [NW-1:0]      out_num,
    output logic [DW-1:0]      out_rem,
    output logic [SW-1:0]      out_side
);

    logic [DW:0]   t;
    logic          q;
    logic [DW-1:0] rem_next;
    logic          valid_reg;
    logic [NW-1:0] num_reg;
    logic [DW-1:0] rem_reg;
    logic [SW-1:0] side_reg;

    assign t = {in_rem, in_num[NW-1]};

    always_comb
    begin
        q = (t >= {1'b0, d});
        if (q)
            rem_next = DW'(t - {1'b0, d});
        else
            rem_next = t[DW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg  <= {in_num[NW-2:0], q};
            rem_reg  <= rem_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_num   = num_reg;
    assign out_rem   = rem_reg;
    assign out_side  = side_reg;

endmodule

`default_nettype wire

### rtl/bac_divider.sv
`timescale 1ns / 1ps
`default_nettype none

// unsigned divider as a chain of NW cells, quotient truncated
module bac_divider #(
    parameter int NW = 56,
    parameter int DW = 17,
    parameter int SW = 24
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire logic [NW-1:0] in_num,
    input  wire logic [SW-1:0] in_side,
    input  wire logic [DW-1:0] d,
    output logic               out_valid,
    output logic [NW-1:0]      quot,
    output logic [SW-1:0]      out_side
);

    logic          v_w [NW+1];
    logic [NW-1:0] n_w [NW+1];
    logic [DW-1:0] r_w [NW+1];
    logic [SW-1:0] s_w [NW+1];

    assign v_w[0] = in_valid;
    assign n_w[0] = in_num;
    assign r_w[0] = '0;
    assign s_w[0] = in_side;

    for (genvar g = 0; g < NW; g++)
    begin : g_cell
        bac_div_cell #(
            .NW (NW),
            .DW (DW),
            .SW (SW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (v_w[g]),
            .in_num    (n_w[g]),
            .in_rem    (r_w[g]),
            .in_side   (s_w[g]),
            .d         (d),
            .out_valid (v_w[g+1]),
            .out_num   (n_w[g+1]),
            .out_rem   (r_w[g+1]),
            .out_side  (s_w[g+1])
        );
    end

    assign out_valid = v_w[NW];
    assign quot      = n_w[NW];
    assign out_side  = s_w[NW];

endmodule

`default_nettype wire

### rtl/bac_norm_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// shifts left by SHIFT when the top SHIFT bits are clear
module bac_norm_cell #(
    parameter int SHIFT = 32
) (
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [63:0] x_in,
    input  wire logic [5:0]  sh_in,
    output logic [63:0]      x_out,
    output logic [5:0]       sh_out
);

    logic [63:0] x_next;
    logic [5:0]  sh_next;
    logic [63:0] x_reg;
    logic [5:0]  sh_reg;

    always_comb
    begin
        if (x_in[63 -: SHIFT] == '0)
        begin
            x_next  = x_in << SHIFT;
            sh_next = sh_in + 6'(SHIFT);
        end
        else
        begin
            x_next  = x_in;
            sh_next = sh_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg  <= x_next;
            sh_reg <= sh_next;
        end
    end

    assign x_out  = x_reg;
    assign sh_out = sh_reg;

endmodule

`default_nettype wire

### rtl/bac_log2.sv
`timescale 1ns / 1ps
`default_nettype none

// log2 of a positive 64-bit integer, q.30, table with linear interpolation
module bac_log2 #(
    parameter int LOG_TABLE_BITS = bac_pkg::LOG_TABLE_BITS
) (
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [63:0] x,
    output logic [36:0]      y
);

    localparam int TBL_N = 1 << LOG_TABLE_BITS;
    localparam int NS    = bac_pkg::NORM_STAGES;

    logic [31:0] tbl [TBL_N+1];
    logic [63:0] xs [NS+1];
    logic [5:0]  ss [NS+1];

    logic [63:0]             n;
    logic [LOG_TABLE_BITS:0] idx;
    logic [LOG_TABLE_BITS:0] idx_p1;
    logic [31:0]             ta;
    logic [31:0]             tb;
    logic [63:0]             prod;

    logic [31:0] a_reg;
    logic [31:0] diff_reg;
    logic [31:0] rem_reg;
    logic [5:0]  e_reg;
    logic [31:0] a2_reg;
    logic [31:0] ip_reg;
    logic [5:0]  e2_reg;
    logic [36:0] y_reg;

    for (genvar i = 0; i <= TBL_N; i++)
    begin : g_tbl
        assign tbl[i] = bac_pkg::log_entry(i, LOG_TABLE_BITS);
    end

    assign xs[0] = x;
    assign ss[0] = '0;

    for (genvar g = 0; g < NS; g++)
    begin : g_norm
        bac_norm_cell #(
            .SHIFT (32 >> g)
        ) u_norm (
            .clk    (clk),
            .en     (en),
            .x_in   (xs[g]),
            .sh_in  (ss[g]),
            .x_out  (xs[g+1]),
            .sh_out (ss[g+1])
        );
    end

    // index from the bits below the leading one, weight from the next 32
    assign n      = xs[NS];
    assign idx    = {1'b0, n[62 -: LOG_TABLE_BITS]};
    assign idx_p1 = idx + 1'b1;
    assign ta     = tbl[idx];
    assign tb     = tbl[idx_p1];
    assign prod   = 64'(diff_reg) * 64'(rem_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg    <= ta;
            diff_reg <= (tb > ta) ? (tb - ta) : 32'd0;
            rem_reg  <= n[62-LOG_TABLE_BITS -: 32];
            e_reg    <= 6'd63 - ss[NS];
            a2_reg   <= a_reg;
            ip_reg   <= prod[63:32];
            e2_reg   <= e_reg;
            y_reg    <= {1'b0, e2_reg, 30'd0} + 37'(a2_reg) + 37'(ip_reg);
        end
    end

    assign y = y_reg;

endmodule

`default_nettype wire

### rtl/baro_adc_to_altitude.sv
`timescale 1ns / 1ps
`default_nettype none

// depth: an item passes 134 register stages between acceptance and the output register,
//   set by the two bit-per-cell divider chains (56 and 57 cells) plus the log2 and
//   multiply stages
// throughput: one item per cycle; the whole pipeline advances whenever the output
//   register is empty or being taken
// reset: rst_n clears all valid bits and loads the configuration registers' defaults
module baro_adc_to_altitude #(
    parameter int LOG_TABLE_BITS = bac_pkg::LOG_TABLE_BITS,
    parameter int ADC_BITS       = bac_pkg::ADC_BITS
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    bac_in_if.sink            sensor,
    bac_out_if.source         altitude,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    typedef struct packed {
        logic        valid;
        logic        bad;
        logic [23:0] temp;
    } side_t;

    // configuration registers
    logic [16:0] full_scale_reg;
    logic [15:0] supply_reg;
    logic [15:0] error_reg;
    logic [31:0] offset_reg;
    logic [31:0] gain_reg;
    logic [31:0] base_reg;
    logic [31:0] alt_scale_reg;

    logic        cfg_wr;
    logic [2:0]  cfg_idx;

    // zero divisors and log arguments are taken as one
    logic [16:0] fs_eff;
    logic [15:0] sup_eff;
    logic [31:0] gain_eff;
    logic [31:0] base_eff;

    logic        adv;

    // stage 0: code times supply
    logic        v0_reg;
    logic [31:0] prod_reg;
    logic [23:0] temp0_reg;

    // divider 1: volts in mV q.24
    logic        d1_valid;
    logic [55:0] volt;
    logic [23:0] d1_temp;

    // stages 2 and 3: subtract error, split sign
    logic               v2_reg;
    logic signed [57:0] num2_reg;
    logic [23:0]        temp2_reg;
    logic               v3_reg;
    logic               neg3_reg;
    logic [56:0]        abs3_reg;
    logic [23:0]        temp3_reg;

    // divider 2: ratio to supply
    logic        d2_valid;
    logic [56:0] quot2;
    logic [24:0] d2_side;

    // stages 4 and 5: signed ratio plus offset
    logic               v4_reg;
    logic signed [57:0] ratio4_reg;
    logic [23:0]        temp4_reg;
    logic               v5_reg;
    logic signed [58:0] s5_reg;
    logic [23:0]        temp5_reg;
    logic               bad5;

    // log2 units run alongside a matching delay line
    logic [36:0] ys;
    logic [36:0] yg;
    logic [36:0] yb;
    side_t       sl_reg [bac_pkg::LOG_LAT];
    side_t       sl_out;

    localparam logic signed [38:0] L2_BIAS = 39'sd17179869184;

    // stage 6: log2(P / P0) and scale times temperature
    logic               v6_reg;
    logic               bad6_reg;
    logic signed [38:0] l2_6_reg;
    logic [55:0]        st6_reg;
    // stage 7: sign and magnitude
    logic        v7_reg;
    logic        bad7_reg;
    logic        pos7_reg;
    logic [37:0] absl7_reg;
    logic [55:0] st7_reg;
    // stage 8: times ln 2
    logic        v8_reg;
    logic        bad8_reg;
    logic        pos8_reg;
    logic [61:0] lmag8_reg;
    logic [55:0] st8_reg;
    // stage 9: round toward minus infinity on the signed value
    logic        v9_reg;
    logic        bad9_reg;
    logic        pos9_reg;
    logic [37:0] lnv9_reg;
    logic [55:0] st9_reg;
    logic [62:0] lmag_up;
    // stage 10: two partial products
    logic        v10_reg;
    logic        bad10_reg;
    logic        pos10_reg;
    logic [69:0] plo10_reg;
    logic [61:0] phi10_reg;
    // stage 11: sum and drop 38 fraction bits
    logic        v11_reg;
    logic        bad11_reg;
    logic        pos11_reg;
    logic [56:0] mag11_reg;
    logic [94:0] psum;

    // output register
    logic               out_valid_reg;
    logic signed [39:0] alt_reg;
    logic               inv_reg;
    logic signed [39:0] alt_next;
    logic               inv_next;

    assign fs_eff   = (full_scale_reg == '0) ? 17'd1 : full_scale_reg;
    assign sup_eff  = (supply_reg == '0) ? 16'd1 : supply_reg;
    assign gain_eff = (gain_reg == '0) ? 32'd1 : gain_reg;
    assign base_eff = (base_reg == '0) ? 32'd1 : base_reg;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_scale_reg <= bac_pkg::RST_FULL_SCALE;
            supply_reg     <= bac_pkg::RST_SUPPLY;
            error_reg      <= bac_pkg::RST_ERROR;
            offset_reg     <= bac_pkg::RST_OFFSET;
            gain_reg       <= bac_pkg::RST_GAIN;
            base_reg       <= bac_pkg::RST_BASE;
            alt_scale_reg  <= bac_pkg::RST_ALT_SCALE;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                bac_pkg::REG_FULL_SCALE: full_scale_reg <= pwdata[16:0];
                bac_pkg::REG_SUPPLY:     supply_reg     <= pwdata[15:0];
                bac_pkg::REG_ERROR:      error_reg      <= pwdata[15:0];
                bac_pkg::REG_OFFSET:     offset_reg     <= pwdata;
                bac_pkg::REG_GAIN:       gain_reg       <= pwdata;
                bac_pkg::REG_BASE:       base_reg       <= pwdata;
                bac_pkg::REG_ALT_SCALE:  alt_scale_reg  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            bac_pkg::REG_FULL_SCALE: prdata = {15'd0, full_scale_reg};
            bac_pkg::REG_SUPPLY:     prdata = {16'd0, supply_reg};
            bac_pkg::REG_ERROR:      prdata = {16'd0, error_reg};
            bac_pkg::REG_OFFSET:     prdata = offset_reg;
            bac_pkg::REG_GAIN:       prdata = gain_reg;
            bac_pkg::REG_BASE:       prdata = base_reg;
            bac_pkg::REG_ALT_SCALE:  prdata = alt_scale_reg;
            default:                 prdata = '0;
        endcase
    end

    // ---------------- flow control ----------------
    // every stage moves together; bubbles travel like items
    assign adv          = !out_valid_reg || altitude.ready;
    assign sensor.ready = adv;

    // ---------------- stage 0 ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (adv)
            v0_reg <= sensor.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // bits above ADC_BITS are dropped
            prod_reg  <= 32'(sensor.adc_code[ADC_BITS-1:0]) * 32'(sup_eff);
            temp0_reg <= sensor.temperature_q8;
        end
    end

    // code * supply * 2^24 / full scale
    bac_divider #(
        .NW (56),
        .DW (17),
        .SW (24)
    ) u_div_volt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v0_reg),
        .in_num    ({prod_reg, 24'd0}),
        .in_side   (temp0_reg),
        .d         (fs_eff),
        .out_valid (d1_valid),
        .quot      (volt),
        .out_side  (d1_temp)
    );

    // ---------------- stages 2 and 3 ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v2_reg <= d1_valid;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // error in mV moved to q.24
            num2_reg  <= $signed({2'b00, volt})
                         - $signed({{18{error_reg[15]}}, error_reg, 24'd0});
            temp2_reg <= d1_temp;
            neg3_reg  <= num2_reg[57];
            abs3_reg  <= num2_reg[57] ? 57'(-num2_reg) : 57'(num2_reg);
            temp3_reg <= temp2_reg;
        end
    end

    // magnitude / supply; sign restored afterwards so the quotient truncates toward zero
    bac_divider #(
        .NW (57),
        .DW (16),
        .SW (25)
    ) u_div_ratio (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v3_reg),
        .in_num    (abs3_reg),
        .in_side   ({neg3_reg, temp3_reg}),
        .d         (sup_eff),
        .out_valid (d2_valid),
        .quot      (quot2),
        .out_side  (d2_side)
    );

    // ---------------- stages 4 and 5 ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (adv)
        begin
            v4_reg <= d2_valid;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ratio4_reg <= d2_side[24] ? -$signed({1'b0, quot2}) : $signed({1'b0, quot2});
            temp4_reg  <= d2_side[23:0];
            s5_reg     <= 59'(ratio4_reg) + 59'($signed(offset_reg));
            temp5_reg  <= temp4_reg;
        end
    end

    // pressure not positive
    assign bad5 = s5_reg[58] || (s5_reg == '0);

    // ---------------- log2 of the scaled pressure, gain and base ----------------
    bac_log2 #(
        .LOG_TABLE_BITS (LOG_TABLE_BITS)
    ) u_log_s (
        .clk (clk),
        .en  (adv),
        .x   (bad5 ? 64'd1 : {5'd0, s5_reg}),
        .y   (ys)
    );

    bac_log2 #(
        .LOG_TABLE_BITS (LOG_TABLE_BITS)
    ) u_log_gain (
        .clk (clk),
        .en  (adv),
        .x   ({32'd0, gain_eff}),
        .y   (yg)
    );

    bac_log2 #(
        .LOG_TABLE_BITS (LOG_TABLE_BITS)
    ) u_log_base (
        .clk (clk),
        .en  (adv),
        .x   ({32'd0, base_eff}),
        .y   (yb)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < bac_pkg::LOG_LAT; i++)
                sl_reg[i] <= '0;
        end
        else if (adv)
        begin
            sl_reg[0] <= '{valid: v5_reg, bad: bad5, temp: temp5_reg};
            for (int i = 1; i < bac_pkg::LOG_LAT; i++)
                sl_reg[i] <= sl_reg[i-1];
        end
    end

    assign sl_out = sl_reg[bac_pkg::LOG_LAT-1];

    // ---------------- stages 6 to 11 ----------------
    assign lmag_up = {1'b0, lmag8_reg} + 63'h0FF_FFFF;
    assign psum    = {1'b0, phi10_reg, 32'd0} + 95'(plo10_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v6_reg  <= 1'b0;
            v7_reg  <= 1'b0;
            v8_reg  <= 1'b0;
            v9_reg  <= 1'b0;
            v10_reg <= 1'b0;
            v11_reg <= 1'b0;
        end
        else if (adv)
        begin
            v6_reg  <= sl_out.valid;
            v7_reg  <= v6_reg;
            v8_reg  <= v7_reg;
            v9_reg  <= v8_reg;
            v10_reg <= v9_reg;
            v11_reg <= v10_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // log2(S) + 16 - log2(gain) - log2(base), q.30
            bad6_reg  <= sl_out.bad;
            l2_6_reg  <= $signed({2'b00, ys}) + L2_BIAS
                         - $signed({2'b00, yg}) - $signed({2'b00, yb});
            st6_reg   <= 56'(alt_scale_reg) * 56'(sl_out.temp);

            bad7_reg  <= bad6_reg;
            pos7_reg  <= !l2_6_reg[38] && (l2_6_reg != '0);
            absl7_reg <= l2_6_reg[38] ? 38'(-l2_6_reg) : 38'(l2_6_reg);
            st7_reg   <= st6_reg;

            bad8_reg  <= bad7_reg;
            pos8_reg  <= pos7_reg;
            lmag8_reg <= 62'(absl7_reg) * 62'(bac_pkg::LN2_Q24);
            st8_reg   <= st7_reg;

            // negative log rounds its magnitude up
            bad9_reg  <= bad8_reg;
            pos9_reg  <= pos8_reg;
            lnv9_reg  <= pos8_reg ? lmag8_reg[61:24] : lmag_up[61:24];
            st9_reg   <= st8_reg;

            bad10_reg <= bad9_reg;
            pos10_reg <= pos9_reg;
            plo10_reg <= 70'(st9_reg[31:0]) * 70'(lnv9_reg);
            phi10_reg <= 62'(st9_reg[55:32]) * 62'(lnv9_reg);

            bad11_reg <= bad10_reg;
            pos11_reg <= pos10_reg;
            mag11_reg <= psum[94:38];
        end
    end

    // ---------------- saturation and output register ----------------
    always_comb
    begin
        priority if (bad11_reg)
        begin
            alt_next = '0;
            inv_next = 1'b1;
        end
        else if (pos11_reg)
        begin
            // pressure above the reference gives a negative altitude
            if (mag11_reg > (57'd1 << 39))
            begin
                alt_next = bac_pkg::ALT_MIN;
                inv_next = 1'b1;
            end
            else
            begin
                alt_next = 40'(-$signed({1'b0, mag11_reg}));
                inv_next = 1'b0;
            end
        end
        else
        begin
            if (mag11_reg > 57'(bac_pkg::ALT_MAX))
            begin
                alt_next = bac_pkg::ALT_MAX;
                inv_next = 1'b1;
            end
            else
            begin
                alt_next = $signed(mag11_reg[39:0]);
                inv_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= v11_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            alt_reg <= alt_next;
            inv_reg <= inv_next;
        end
    end

    assign altitude.valid        = out_valid_reg;
    assign altitude.altitude_q16 = alt_reg;
    assign altitude.invalid      = inv_reg;

    // ---------------- checks ----------------
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> sensor.ready)
        else $error("input stalled with empty output register");

    a_last_stage_lands: assert property (@(posedge clk) disable iff (!rst_n)
        v11_reg && adv |=> out_valid_reg)
        else $error("item lost between last stage and output register");

    a_flag_on_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && inv_reg && (alt_reg != '0)
        |-> (alt_reg == bac_pkg::ALT_MAX) || (alt_reg == bac_pkg::ALT_MIN))
        else $error("invalid flag on an unsaturated altitude");

endmodule

`default_nettype wire
